@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files; the palette line syntax checker includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define PLSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLSC_ASSERT(label, clk, rst, prop)
`define PLSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PLSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/plsc_pkg.sv @@
// types and constants of the palette line syntax checker
package plsc_pkg;

  typedef logic [7:0] char_t;

  localparam int unsigned CNT_W = 3;
  typedef logic [CNT_W-1:0] count_t;
  localparam count_t HEX_DIGITS = count_t'(6);

  typedef logic [3:0] phase_t;
  localparam phase_t PH_LEAD      = 4'd0;
  localparam phase_t PH_NAME      = 4'd1;
  localparam phase_t PH_SIZE_WS   = 4'd2;
  localparam phase_t PH_ZEROS     = 4'd3;
  localparam phase_t PH_SIZE      = 4'd4;
  localparam phase_t PH_WS_FIRST  = 4'd5;
  localparam phase_t PH_HEX_FIRST = 4'd6;
  localparam phase_t PH_WS_SECOND = 4'd7;
  localparam phase_t PH_HEX_LATER = 4'd8;
  localparam phase_t PH_WS_LATER  = 4'd9;

  localparam char_t CH_END   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0d;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF    = 8'h66;
  localparam char_t CH_TILDE = 8'h7e;

endpackage

@@ hdl/palette_line_syntax_checker.sv @@
// palette line syntax checker top level
//
// character channel: one ascii character per transaction, 0 ends the line.
// result channel: one transaction per line, carrying line_valid, sent only
// when the end-of-line character has been processed.
// a character that is taken is held in an input register and processed from
// there, where the phase, digit count and error flag are updated and, for the
// end of a line, the result register is loaded, from which the result is taken.
// throughput is one character per cycle while no end-of-line character waits
// on a result; the single phase register with its digit counter carries the
// dependency from one character to the next.
// while a result waits, ordinary characters keep flowing; an end-of-line
// character that meets a waiting result stays in the input register, and
// character_ready is low until the cycle in which the result is taken.
// reset returns the parser to the leading whitespace phase with a clear
// error flag and empties both the input and the result register.
module palette_line_syntax_checker (
  input  logic            clk,
  input  logic            rst,
  input  plsc_pkg::char_t character,
  input  logic            character_valid,
  output logic            character_ready,
  output logic            line_valid,
  output logic            result_valid,
  input  logic            result_ready
);
  import plsc_pkg::*;

`include "assert_macros.svh"

  function automatic logic is_ws(char_t c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_prn(char_t c);
    return (c >= CH_SPACE) && (c <= CH_TILDE);
  endfunction

  function automatic logic is_dec(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(char_t c);
    return is_dec(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
  endfunction

  logic   in_vld;
  char_t  in_char;
  phase_t phase, phase_next;
  count_t count, count_next;
  logic   failed, failed_next;
  logic   ok;
  logic   is_end;
  logic   proc;

  assign is_end          = (in_char == CH_END);
  assign proc            = in_vld && (!is_end || !result_valid || result_ready);
  assign character_ready = !in_vld || proc;

  assign ok = !failed && ((phase == PH_WS_LATER) ||
                          (phase == PH_HEX_LATER && count == HEX_DIGITS));

  always_comb begin
    phase_next  = phase;
    count_next  = count;
    failed_next = failed;
    if (is_end) begin
      phase_next  = PH_LEAD;
      count_next  = '0;
      failed_next = 1'b0;
    end else if (!failed) begin
      unique case (phase)
        PH_LEAD: begin
          if (in_char != CH_SPACE && in_char != CH_HASH && is_prn(in_char)) begin
            phase_next = PH_NAME;
          end else if (!is_ws(in_char)) begin
            failed_next = 1'b1;
          end
        end
        PH_NAME: begin
          if (is_ws(in_char)) begin
            phase_next = PH_SIZE_WS;
          end else if (!is_prn(in_char)) begin
            failed_next = 1'b1;
          end
        end
        PH_SIZE_WS: begin
          if (in_char == CH_ZERO) begin
            phase_next = PH_ZEROS;
          end else if (is_dec(in_char)) begin
            phase_next = PH_SIZE;
          end else if (!is_ws(in_char)) begin
            failed_next = 1'b1;
          end
        end
        PH_ZEROS: begin
          if (in_char != CH_ZERO) begin
            if (is_dec(in_char)) begin
              phase_next = PH_SIZE;
            end else begin
              failed_next = 1'b1;
            end
          end
        end
        PH_SIZE: begin
          if (is_ws(in_char)) begin
            phase_next = PH_WS_FIRST;
          end else if (!is_dec(in_char)) begin
            failed_next = 1'b1;
          end
        end
        PH_WS_FIRST, PH_WS_SECOND, PH_WS_LATER: begin
          if (is_hex(in_char)) begin
            phase_next = (phase == PH_WS_FIRST) ? PH_HEX_FIRST : PH_HEX_LATER;
            count_next = count_t'(1);
          end else if (!is_ws(in_char)) begin
            failed_next = 1'b1;
          end
        end
        PH_HEX_FIRST, PH_HEX_LATER: begin
          if (count < HEX_DIGITS) begin
            if (is_hex(in_char)) begin
              count_next = count + count_t'(1);
            end else begin
              failed_next = 1'b1;
            end
          end else if (is_ws(in_char)) begin
            phase_next = (phase == PH_HEX_FIRST) ? PH_WS_SECOND : PH_WS_LATER;
            count_next = '0;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (character_ready) begin
      in_vld <= character_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (character_ready) begin
      in_char <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEAD;
      count  <= '0;
      failed <= 1'b0;
    end else if (proc) begin
      phase  <= phase_next;
      count  <= count_next;
      failed <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc && is_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_end) begin
      line_valid <= ok;
    end
  end

  `PLSC_ASSERT(a_phase_range, clk, rst, phase <= PH_WS_LATER)
  `PLSC_ASSERT(a_count_range, clk, rst, count <= HEX_DIGITS)
  `PLSC_ASSERT_IMPL(a_count_phase, clk, rst, count != '0,
    phase == PH_HEX_FIRST || phase == PH_HEX_LATER)
  `PLSC_ASSERT_NEXT(a_end_restart, clk, rst, proc && is_end,
    phase == PH_LEAD && count == '0 && !failed && result_valid)
  `PLSC_ASSERT_IMPL(a_result_source, clk, rst, $rose(result_valid),
    $past(proc && is_end))

endmodule
